>>> hw/rtl/assert_macros.svh
// Assertion macros used by the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, switched off while reset is held.
`define CHK_ASSERT(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) prop) \
        else $error(msg);

// Clocked assertion that also holds across reset.
`define CHK_ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) prop) \
        else $error(msg);

`endif

>>> hw/rtl/isu_pkg.sv
// Types and constants for the Ising Metropolis spin update block.
`default_nettype none

package isu_pkg;

    // Lattice geometry
    localparam int GRID_SIDE  = 128;
    localparam int ROW_W      = $clog2(GRID_SIDE);
    localparam int SITE_COUNT = GRID_SIDE * GRID_SIDE;

    // Field widths
    localparam int SUM_W  = 16;
    localparam int TH_W   = 17;
    localparam int IV_W   = 24;
    localparam int RAND_W = 16;
    localparam int STEP_W = 32;
    localparam int AGREE_W = 3;

    // Commands
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_STEP = 1'b1;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TH_DE4   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_TH_DE8   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_INTERVAL = 2'd2;

    // Reset values
    localparam logic [TH_W-1:0] TH_DE4_RESET   = 17'd1200;
    localparam logic [TH_W-1:0] TH_DE8_RESET   = 17'd22;
    localparam logic [IV_W-1:0] INTERVAL_RESET = 24'd100000;
    localparam logic signed [SUM_W-1:0] SUM_RESET = SUM_W'(-SITE_COUNT);

    // Magnetization change of one spin flip
    localparam logic signed [SUM_W-1:0] SUM_STEP = 16'sd2;

    // Neighbor agreement counts for dE = 0 and dE = 4 (dE = 4k - 8)
    localparam logic [AGREE_W-1:0] AGREE_ZERO_DE = 3'd2;
    localparam logic [AGREE_W-1:0] AGREE_DE4     = 3'd3;

    typedef logic [GRID_SIDE-1:0] row_t;

    // Lattice RAM request: one write and one read port
    typedef struct packed {
        logic             wr_en;
        logic [ROW_W-1:0] wr_row;
        row_t             wr_data;
        logic             rd_en;
        logic [ROW_W-1:0] rd_row;
    } ram_req_t;

    // Live configuration
    typedef struct packed {
        logic [TH_W-1:0] th_de4;
        logic [TH_W-1:0] th_de8;
        logic [IV_W-1:0] interval;
    } cfg_t;

endpackage

`default_nettype wire

>>> hw/rtl/isu_lattice_ram.sv
// Row-wide spin lattice RAM with a clearing sweep after reset.
`default_nettype none

module isu_lattice_ram (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire isu_pkg::ram_req_t req,
    output isu_pkg::row_t          rd_data,
    output logic                   ready
);

    isu_pkg::row_t lattice_mem [isu_pkg::GRID_SIDE];
    isu_pkg::row_t rd_data_reg;

    logic [isu_pkg::ROW_W-1:0] clr_row_reg, clr_row_next;
    logic                      clr_busy_reg, clr_busy_next;

    // Clear sweep: one row per cycle
    always_comb begin
        clr_row_next  = clr_row_reg;
        clr_busy_next = clr_busy_reg;
        if (clr_busy_reg) begin
            clr_row_next  = clr_row_reg + isu_pkg::ROW_W'(1);
            clr_busy_next = (clr_row_reg != isu_pkg::ROW_W'(isu_pkg::GRID_SIDE - 1));
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_row_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end else begin
            clr_row_reg  <= clr_row_next;
            clr_busy_reg <= clr_busy_next;
        end
    end

    // Memory: one write, one registered read per cycle
    always_ff @(posedge aclk) begin
        if (clr_busy_reg) begin
            lattice_mem[clr_row_reg] <= '0;
        end else if (req.wr_en) begin
            lattice_mem[req.wr_row] <= req.wr_data;
        end
        if (req.rd_en) begin
            rd_data_reg <= lattice_mem[req.rd_row];
        end
    end

    assign rd_data = rd_data_reg;
    assign ready   = !clr_busy_reg;

endmodule

`default_nettype wire

>>> hw/rtl/isu_seq.sv
// Sequencer and datapath: row fetches, neighbor accumulation, flip decision.
`default_nettype none

module isu_seq (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    input  wire logic                              s_valid,
    output logic                                   s_ready,
    input  wire logic                              s_command,
    input  wire logic [isu_pkg::ROW_W-1:0]         s_row,
    input  wire logic [isu_pkg::ROW_W-1:0]         s_col,
    input  wire logic                              s_spin_value,
    input  wire logic [isu_pkg::RAND_W-1:0]        s_rand_fraction,
    input  wire isu_pkg::cfg_t                     cfg,
    input  wire logic                              ram_ready,
    output isu_pkg::ram_req_t                      ram_req,
    input  wire isu_pkg::row_t                     ram_rd_data,
    output logic                                   m_valid,
    input  wire logic                              m_ready,
    output logic [isu_pkg::STEP_W-1:0]             m_step_index,
    output logic signed [isu_pkg::SUM_W-1:0]       m_magnetization
);

    localparam logic [1:0] ST_IDLE   = 2'd0;
    localparam logic [1:0] ST_CENTER = 2'd1;
    localparam logic [1:0] ST_UP     = 2'd2;
    localparam logic [1:0] ST_DOWN   = 2'd3;

    logic [1:0] state_reg, state_next;

    logic                          cmd_reg, cmd_next;
    logic [isu_pkg::ROW_W-1:0]     row_reg, row_next;
    logic [isu_pkg::ROW_W-1:0]     col_reg, col_next;
    logic                          spin_reg, spin_next;
    logic [isu_pkg::RAND_W-1:0]    rand_reg, rand_next;
    isu_pkg::row_t                 cen_row_reg, cen_row_next;
    logic                          s_bit_reg, s_bit_next;
    logic [isu_pkg::AGREE_W-1:0]   agree_reg, agree_next;

    logic signed [isu_pkg::SUM_W-1:0] sum_reg, sum_next;
    logic [isu_pkg::STEP_W-1:0]       steps_reg, steps_next;
    logic [isu_pkg::IV_W-1:0]         countdown_reg, countdown_next;

    logic                             m_valid_reg, m_valid_next;
    logic [isu_pkg::STEP_W-1:0]       m_step_reg, m_step_next;
    logic signed [isu_pkg::SUM_W-1:0] m_mag_reg, m_mag_next;

    logic [isu_pkg::ROW_W-1:0]   col_l, col_r, sel_col;
    logic                        cur_bit, ref_bit, acc_a, acc_b;
    logic [isu_pkg::AGREE_W-1:0] acc_base, agree_acc;
    logic [isu_pkg::TH_W-1:0]    rand_ext;
    logic                        flip, report, out_free;
    isu_pkg::row_t               load_row, flip_mask;

    // Wrapped column neighbors
    assign col_l   = col_reg - isu_pkg::ROW_W'(1);
    assign col_r   = col_reg + isu_pkg::ROW_W'(1);
    assign cur_bit = ram_rd_data[col_reg];

    // Shared agreement accumulator: left/right in CENTER, up in UP, down in DOWN
    assign ref_bit   = (state_reg == ST_CENTER) ? cur_bit : s_bit_reg;
    assign sel_col   = (state_reg == ST_CENTER) ? col_l : col_reg;
    assign acc_a     = (ram_rd_data[sel_col] == ref_bit);
    assign acc_b     = (state_reg == ST_CENTER) && (ram_rd_data[col_r] == ref_bit);
    assign acc_base  = (state_reg == ST_CENTER) ? '0 : agree_reg;
    assign agree_acc = acc_base + {2'b00, acc_a} + {2'b00, acc_b};

    // Metropolis acceptance
    assign rand_ext = {1'b0, rand_reg};
    always_comb begin
        priority if (agree_acc <= isu_pkg::AGREE_ZERO_DE) begin
            flip = 1'b1;
        end else if (agree_acc == isu_pkg::AGREE_DE4) begin
            flip = (rand_ext < cfg.th_de4);
        end else begin
            flip = (rand_ext < cfg.th_de8);
        end
    end

    assign report   = (countdown_reg == '0);
    assign out_free = !m_valid_reg || m_ready;

    always_comb begin
        load_row          = ram_rd_data;
        load_row[col_reg] = spin_reg;
    end
    assign flip_mask = isu_pkg::row_t'(flip) << col_reg;

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        spin_next      = spin_reg;
        rand_next      = rand_reg;
        cen_row_next   = cen_row_reg;
        s_bit_next     = s_bit_reg;
        agree_next     = agree_reg;
        sum_next       = sum_reg;
        steps_next     = steps_reg;
        countdown_next = countdown_reg;
        m_valid_next   = m_valid_reg;
        m_step_next    = m_step_reg;
        m_mag_next     = m_mag_reg;
        ram_req        = '0;
        s_ready        = (state_reg == ST_IDLE) && ram_ready;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid && s_ready) begin
                    cmd_next       = s_command;
                    row_next       = s_row;
                    col_next       = s_col;
                    spin_next      = s_spin_value;
                    rand_next      = s_rand_fraction;
                    ram_req.rd_en  = 1'b1;
                    ram_req.rd_row = s_row;
                    state_next     = ST_CENTER;
                end
            end
            ST_CENTER: begin
                cen_row_next = ram_rd_data;
                s_bit_next   = cur_bit;
                agree_next   = agree_acc;
                if (cmd_reg == isu_pkg::CMD_LOAD) begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_row  = row_reg;
                    ram_req.wr_data = load_row;
                    if (spin_reg != cur_bit) begin
                        sum_next = cur_bit ? sum_reg - isu_pkg::SUM_STEP
                                           : sum_reg + isu_pkg::SUM_STEP;
                    end
                    state_next = ST_IDLE;
                end else begin
                    ram_req.rd_en  = 1'b1;
                    ram_req.rd_row = row_reg - isu_pkg::ROW_W'(1);
                    state_next     = ST_UP;
                end
            end
            ST_UP: begin
                agree_next     = agree_acc;
                ram_req.rd_en  = 1'b1;
                ram_req.rd_row = row_reg + isu_pkg::ROW_W'(1);
                state_next     = ST_DOWN;
            end
            ST_DOWN: begin
                // Hold here while a report would overwrite an untaken word
                if (!report || out_free) begin
                    ram_req.wr_en   = 1'b1;
                    ram_req.wr_row  = row_reg;
                    ram_req.wr_data = cen_row_reg ^ flip_mask;
                    if (flip) begin
                        sum_next = s_bit_reg ? sum_reg - isu_pkg::SUM_STEP
                                             : sum_reg + isu_pkg::SUM_STEP;
                    end
                    steps_next = steps_reg + isu_pkg::STEP_W'(1);
                    if (report) begin
                        countdown_next = (cfg.interval == '0) ? '0
                                       : cfg.interval - isu_pkg::IV_W'(1);
                        m_valid_next   = 1'b1;
                        m_step_next    = steps_reg;
                        m_mag_next     = sum_next;
                    end else begin
                        countdown_next = countdown_reg - isu_pkg::IV_W'(1);
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and running state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            sum_reg       <= isu_pkg::SUM_RESET;
            steps_reg     <= '0;
            countdown_reg <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            sum_reg       <= sum_next;
            steps_reg     <= steps_next;
            countdown_reg <= countdown_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload
    always_ff @(posedge aclk) begin
        cmd_reg     <= cmd_next;
        row_reg     <= row_next;
        col_reg     <= col_next;
        spin_reg    <= spin_next;
        rand_reg    <= rand_next;
        cen_row_reg <= cen_row_next;
        s_bit_reg   <= s_bit_next;
        agree_reg   <= agree_next;
        m_step_reg  <= m_step_next;
        m_mag_reg   <= m_mag_next;
    end

    assign m_valid         = m_valid_reg;
    assign m_step_index    = m_step_reg;
    assign m_magnetization = m_mag_reg;

endmodule

`default_nettype wire

>>> hw/rtl/ising_metropolis_spin_update.sv
// A step word's report is registered at the end of DOWN, after CENTER and UP; a load writes
// its row in CENTER. A word is taken only in IDLE, once the previous one is done; the site row
// and the rows above and below come through the single read port of the lattice RAM in turn.
// A reporting step holds in its last cycle while the previous report is untaken.
// Reset: synchronous, active low; afterwards a clearing pass empties the lattice row by row
// with s_ready low. Configuration writes are taken at all times.
`default_nettype none

module ising_metropolis_spin_update (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    output logic                                     s_ready,
    input  wire logic                                s_command,
    input  wire logic [isu_pkg::ROW_W-1:0]           s_row,
    input  wire logic [isu_pkg::ROW_W-1:0]           s_col,
    input  wire logic                                s_spin_value,
    input  wire logic [isu_pkg::RAND_W-1:0]          s_rand_fraction,
    output logic                                     m_valid,
    input  wire logic                                m_ready,
    output logic [isu_pkg::STEP_W-1:0]               m_step_index,
    output logic signed [isu_pkg::SUM_W-1:0]         m_magnetization,
    input  wire logic                                cfg_valid,
    output logic                                     cfg_ready,
    input  wire logic [isu_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [isu_pkg::IV_W-1:0]            cfg_data
);

    isu_pkg::cfg_t     cfg_reg, cfg_next;
    isu_pkg::ram_req_t ram_req;
    isu_pkg::row_t     ram_rd_data;
    logic              ram_ready;

    // Configuration register file
    assign cfg_ready = 1'b1;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                isu_pkg::REG_TH_DE4:   cfg_next.th_de4   = cfg_data[isu_pkg::TH_W-1:0];
                isu_pkg::REG_TH_DE8:   cfg_next.th_de8   = cfg_data[isu_pkg::TH_W-1:0];
                isu_pkg::REG_INTERVAL: cfg_next.interval = cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.th_de4   <= isu_pkg::TH_DE4_RESET;
            cfg_reg.th_de8   <= isu_pkg::TH_DE8_RESET;
            cfg_reg.interval <= isu_pkg::INTERVAL_RESET;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    isu_lattice_ram u_ram (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (ram_req),
        .rd_data (ram_rd_data),
        .ready   (ram_ready)
    );

    isu_seq u_seq (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_row           (s_row),
        .s_col           (s_col),
        .s_spin_value    (s_spin_value),
        .s_rand_fraction (s_rand_fraction),
        .cfg             (cfg_reg),
        .ram_ready       (ram_ready),
        .ram_req         (ram_req),
        .ram_rd_data     (ram_rd_data),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_step_index    (m_step_index),
        .m_magnetization (m_magnetization)
    );

endmodule

`default_nettype wire

>>> hw/rtl/isu_checker.sv
// Port-level checker for the spin update block, bound to the top level.
`default_nettype none
`include "assert_macros.svh"

module isu_checker (
    input  wire logic                                aclk,
    input  wire logic                                aresetn,
    input  wire logic                                s_valid,
    input  wire logic                                s_ready,
    input  wire logic                                m_valid,
    input  wire logic                                m_ready,
    input  wire logic [isu_pkg::STEP_W-1:0]          m_step_index,
    input  wire logic signed [isu_pkg::SUM_W-1:0]    m_magnetization
);

    // A waiting report word holds its step index
    `CHK_ASSERT(a_out_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid && $stable(m_step_index), "report word changed while stalled")

    // One word at a time: busy right after an accept
    `CHK_ASSERT(a_busy_after_accept, aclk, aresetn, s_valid && s_ready |=> !s_ready, "input accepted back to back")

    // Lattice clearing pass keeps the input closed after reset
    `CHK_ASSERT_ALWAYS(a_clear_after_reset, aclk, !aresetn |=> !s_ready, "input open during clearing pass")

    // Even site count: magnetization is always even
    `CHK_ASSERT(a_mag_even, aclk, aresetn, m_valid |-> !m_magnetization[0], "odd magnetization reported")

endmodule

bind ising_metropolis_spin_update isu_checker u_isu_checker (.*);

`default_nettype wire

>>> tb/tb_ising_metropolis_spin_update.sv
// Self-checking testbench for the Ising Metropolis spin update block.
`timescale 1ns / 100ps

module tb_ising_metropolis_spin_update;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int DRAIN_CYCLES = 16;
    localparam int HOLD_CYCLES  = 400;
    localparam int MAX_SHOWN    = 10;

    // Index with no register behind it; writes must leave the block unchanged
    localparam logic [isu_pkg::CFG_IDX_W-1:0] REG_SPARE = 2'd3;

    typedef struct packed {
        logic                       command;
        logic [isu_pkg::ROW_W-1:0]  row;
        logic [isu_pkg::ROW_W-1:0]  col;
        logic                       spin_value;
        logic [isu_pkg::RAND_W-1:0] rand_fraction;
    } site_word_t;

    typedef struct packed {
        logic [isu_pkg::STEP_W-1:0]       step_index;
        logic signed [isu_pkg::SUM_W-1:0] magnetization;
    } report_t;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;

    logic                             s_valid = 1'b0;
    logic                             s_ready;
    logic                             s_command = 1'b0;
    logic [isu_pkg::ROW_W-1:0]        s_row = '0;
    logic [isu_pkg::ROW_W-1:0]        s_col = '0;
    logic                             s_spin_value = 1'b0;
    logic [isu_pkg::RAND_W-1:0]       s_rand_fraction = '0;
    logic                             m_valid;
    logic                             m_ready = 1'b0;
    logic [isu_pkg::STEP_W-1:0]       m_step_index;
    logic signed [isu_pkg::SUM_W-1:0] m_magnetization;
    logic                             cfg_valid = 1'b0;
    logic                             cfg_ready;
    logic [isu_pkg::CFG_IDX_W-1:0]    cfg_index = '0;
    logic [isu_pkg::IV_W-1:0]         cfg_data = '0;

    ising_metropolis_spin_update u_dut (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .s_command       (s_command),
        .s_row           (s_row),
        .s_col           (s_col),
        .s_spin_value    (s_spin_value),
        .s_rand_fraction (s_rand_fraction),
        .m_valid         (m_valid),
        .m_ready         (m_ready),
        .m_step_index    (m_step_index),
        .m_magnetization (m_magnetization),
        .cfg_valid       (cfg_valid),
        .cfg_ready       (cfg_ready),
        .cfg_index       (cfg_index),
        .cfg_data        (cfg_data)
    );

    always #2 aclk = ~aclk;

    // Shadow lattice and counters, advanced on every accepted word
    bit                       lattice_spin [isu_pkg::GRID_SIDE][isu_pkg::GRID_SIDE];
    int                       spin_total = -isu_pkg::SITE_COUNT;
    bit [isu_pkg::STEP_W-1:0] step_count = '0;
    bit [isu_pkg::IV_W-1:0]   report_countdown = '0;
    bit [isu_pkg::TH_W-1:0]   th_de4 = isu_pkg::TH_DE4_RESET;
    bit [isu_pkg::TH_W-1:0]   th_de8 = isu_pkg::TH_DE8_RESET;
    bit [isu_pkg::IV_W-1:0]   report_interval = isu_pkg::INTERVAL_RESET;

    site_word_t pending_words[$];
    report_t    expected_reports[$];
    site_word_t offered;

    int src_idle_pct = 0;
    int sink_stall_pct = 0;
    int hold_requests = 0;
    int mismatch_count = 0;
    int reports_checked = 0;
    int load_count = 0;
    int uphill_accepts = 0;
    int uphill_rejects = 0;
    int cfg_writes = 0;
    int cycle_count = 0;

    function automatic int spin_of(input int r, input int c);
        int rw;
        int cw;
        rw = (r + isu_pkg::GRID_SIDE) % isu_pkg::GRID_SIDE;
        cw = (c + isu_pkg::GRID_SIDE) % isu_pkg::GRID_SIDE;
        return lattice_spin[rw][cw] ? 1 : -1;
    endfunction

    // Apply one word to the shadow lattice; queue a report when one is due
    function automatic void metropolis_update(input site_word_t w);
        int  r;
        int  c;
        int  s;
        int  nsum;
        int  de;
        bit  flip;
        bit [isu_pkg::IV_W-1:0] iv;
        r = w.row;
        c = w.col;
        s = spin_of(r, c);
        if (w.command == isu_pkg::CMD_LOAD) begin
            spin_total += (w.spin_value ? 1 : -1) - s;
            lattice_spin[r][c] = w.spin_value;
            load_count++;
            return;
        end
        nsum = spin_of(r, c - 1) + spin_of(r, c + 1) + spin_of(r - 1, c) + spin_of(r + 1, c);
        de = 2 * s * nsum;
        if (de <= 0) begin
            flip = 1'b1;
        end else if (de == 4) begin
            flip = {1'b0, w.rand_fraction} < th_de4;
        end else begin
            flip = {1'b0, w.rand_fraction} < th_de8;
        end
        if (de > 0) begin
            if (flip) uphill_accepts++;
            else uphill_rejects++;
        end
        if (flip) begin
            lattice_spin[r][c] = ~lattice_spin[r][c];
            spin_total -= 2 * s;
        end
        if (report_countdown == 0) begin
            iv = (report_interval == 0) ? isu_pkg::IV_W'(1) : report_interval;
            report_countdown = iv - 1'b1;
            expected_reports.push_back('{step_index: step_count,
                                         magnetization: isu_pkg::SUM_W'(spin_total)});
        end else begin
            report_countdown = report_countdown - 1'b1;
        end
        step_count = step_count + 1'b1;
    endfunction

    function automatic site_word_t load_word(input int r, input int c, input bit v);
        site_word_t w;
        w.command = isu_pkg::CMD_LOAD;
        w.row = isu_pkg::ROW_W'(r);
        w.col = isu_pkg::ROW_W'(c);
        w.spin_value = v;
        w.rand_fraction = isu_pkg::RAND_W'($urandom);
        return w;
    endfunction

    function automatic site_word_t step_word(input int r, input int c, input int rnd);
        site_word_t w;
        w.command = isu_pkg::CMD_STEP;
        w.row = isu_pkg::ROW_W'(r);
        w.col = isu_pkg::ROW_W'(c);
        w.spin_value = 1'($urandom);
        w.rand_fraction = isu_pkg::RAND_W'(rnd);
        return w;
    endfunction

    // Random words, mostly clustered in a small window so neighbors interact
    task automatic queue_random(input int count);
        logic [isu_pkg::ROW_W-1:0] br;
        logic [isu_pkg::ROW_W-1:0] bc;
        site_word_t w;
        int k;
        int pick;
        for (k = 0; k < count; k++) begin
            if (k % 40 == 0) begin
                br = ($urandom_range(0, 3) == 0) ?
                     isu_pkg::ROW_W'($urandom_range(isu_pkg::GRID_SIDE - 4,
                                                    isu_pkg::GRID_SIDE - 1)) :
                     isu_pkg::ROW_W'($urandom);
                bc = ($urandom_range(0, 3) == 0) ?
                     isu_pkg::ROW_W'($urandom_range(isu_pkg::GRID_SIDE - 4,
                                                    isu_pkg::GRID_SIDE - 1)) :
                     isu_pkg::ROW_W'($urandom);
            end
            pick = $urandom_range(0, 99);
            if (pick < 8) begin
                w.command = 1'($urandom);
                w.row = isu_pkg::ROW_W'($urandom);
                w.col = isu_pkg::ROW_W'($urandom);
                w.spin_value = 1'($urandom);
                w.rand_fraction = isu_pkg::RAND_W'($urandom);
            end else begin
                w.command = (pick < 43) ? isu_pkg::CMD_LOAD : isu_pkg::CMD_STEP;
                w.row = br + isu_pkg::ROW_W'($urandom_range(0, 3));
                w.col = bc + isu_pkg::ROW_W'($urandom_range(0, 3));
                w.spin_value = 1'($urandom);
                case ($urandom_range(0, 3))
                    0: w.rand_fraction = isu_pkg::RAND_W'($urandom_range(0, 127));
                    1: w.rand_fraction = isu_pkg::RAND_W'($urandom_range(0, 4095));
                    default: w.rand_fraction = isu_pkg::RAND_W'($urandom);
                endcase
            end
            pending_words.push_back(w);
        end
    endtask

    task automatic write_reg(input logic [isu_pkg::CFG_IDX_W-1:0] idx,
                             input logic [isu_pkg::IV_W-1:0] data);
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid <= 1'b0;
        case (idx)
            isu_pkg::REG_TH_DE4:   th_de4 = data[isu_pkg::TH_W-1:0];
            isu_pkg::REG_TH_DE8:   th_de8 = data[isu_pkg::TH_W-1:0];
            isu_pkg::REG_INTERVAL: report_interval = data;
            default: ;
        endcase
        cfg_writes++;
    endtask

    // Wait until every word is taken and every report has come, and the block stays quiet
    task automatic settle();
        int quiet;
        quiet = 0;
        while (quiet < DRAIN_CYCLES) begin
            @(posedge aclk);
            if (pending_words.size() != 0 || s_valid || expected_reports.size() != 0)
                quiet = 0;
            else
                quiet++;
        end
    endtask

    // Input driver
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                metropolis_update(offered);
            end
            if (!s_valid || s_ready) begin
                if (pending_words.size() != 0 && $urandom_range(0, 99) >= src_idle_pct) begin
                    offered = pending_words.pop_front();
                    s_valid         <= 1'b1;
                    s_command       <= offered.command;
                    s_row           <= offered.row;
                    s_col           <= offered.col;
                    s_spin_value    <= offered.spin_value;
                    s_rand_fraction <= offered.rand_fraction;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Long receiver hold-off, counted down on its own
    int hold_left = 0;
    int hold_seen = 0;
    always @(posedge aclk) begin
        if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
        end else if (hold_left > 0) begin
            hold_left--;
        end
    end

    // Report monitor and receiver back-pressure
    always @(posedge aclk) begin
        report_t exp_rpt;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_reports.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_SHOWN)
                        $display("ERROR: unexpected report step_index=%0d magnetization=%0d",
                                 m_step_index, m_magnetization);
                end else begin
                    exp_rpt = expected_reports.pop_front();
                    reports_checked++;
                    if (m_step_index !== exp_rpt.step_index ||
                        m_magnetization !== exp_rpt.magnetization) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_SHOWN) begin
                            $display("ERROR: report mismatch: step_index exp %0d got %0d",
                                     exp_rpt.step_index, m_step_index);
                            $display("       magnetization exp %0d got %0d",
                                     exp_rpt.magnetization, m_magnetization);
                        end
                    end
                end
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
            end else begin
                m_ready <= ($urandom_range(0, 99) >= sink_stall_pct);
            end
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Timeout after %0d cycles, %0d reports outstanding",
                     cycle_count, expected_reports.size());
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Stimulus sequence
    initial begin
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed: corner sites and their wrapped neighbors, thresholds at reset
        write_reg(isu_pkg::REG_INTERVAL, isu_pkg::IV_W'(1));
        pending_words.push_back(step_word(0, 0, 0));           // uphill 8, below threshold
        pending_words.push_back(step_word(0, 0, 65535));       // downhill, always flips
        pending_words.push_back(step_word(0, 0, 22));          // uphill 8, at threshold
        pending_words.push_back(step_word(0, 0, 21));          // uphill 8, just below
        pending_words.push_back(load_word(127, 0, 1'b1));
        pending_words.push_back(load_word(0, 127, 1'b1));
        pending_words.push_back(step_word(0, 0, 65535));       // zero energy change
        pending_words.push_back(load_word(1, 0, 1'b1));
        pending_words.push_back(step_word(0, 0, 65535));       // downhill 4
        pending_words.push_back(step_word(0, 0, 1200));        // uphill 4, at threshold
        pending_words.push_back(step_word(0, 0, 1199));        // uphill 4, just below
        pending_words.push_back(load_word(0, 1, 1'b1));
        pending_words.push_back(step_word(0, 0, 0));           // downhill 8
        pending_words.push_back(step_word(0, 0, 65535));       // uphill 8, rejected
        pending_words.push_back(load_word(127, 127, 1'b1));
        pending_words.push_back(step_word(127, 127, 0));       // high corner wrap
        pending_words.push_back(load_word(127, 0, 1'b1));      // same value again
        pending_words.push_back(load_word(127, 0, 1'b0));
        pending_words.push_back(step_word(127, 0, 40000));
        pending_words.push_back(step_word(64, 127, 65535));
        pending_words.push_back(load_word(127, 127, 1'b0));
        pending_words.push_back(step_word(127, 127, 0));
        settle();

        // Uphill 4 always accepted, uphill 8 never
        write_reg(isu_pkg::REG_TH_DE4, isu_pkg::IV_W'(65536));
        write_reg(isu_pkg::REG_TH_DE8, isu_pkg::IV_W'(0));
        write_reg(isu_pkg::REG_INTERVAL, isu_pkg::IV_W'(3));
        queue_random(300);
        settle();

        // Mirror extremes, zero interval, sender gaps
        src_idle_pct = 71;
        write_reg(isu_pkg::REG_TH_DE4, isu_pkg::IV_W'(0));
        write_reg(isu_pkg::REG_TH_DE8, isu_pkg::IV_W'(65536));
        write_reg(isu_pkg::REG_INTERVAL, isu_pkg::IV_W'(0));
        queue_random(300);
        settle();

        // Random thresholds, receiver stalls, sender waits for all reports midway
        src_idle_pct = 0;
        sink_stall_pct = 71;
        write_reg(isu_pkg::REG_TH_DE4, isu_pkg::IV_W'($urandom_range(0, 65536)));
        write_reg(isu_pkg::REG_TH_DE8, isu_pkg::IV_W'($urandom_range(0, 65536)));
        write_reg(isu_pkg::REG_INTERVAL, isu_pkg::IV_W'(2));
        queue_random(150);
        settle();
        queue_random(150);
        settle();

        // Both sides idle, plus a long receiver hold-off to back the block up
        src_idle_pct = 19;
        sink_stall_pct = 19;
        write_reg(isu_pkg::REG_TH_DE4, isu_pkg::IV_W'(30000));
        write_reg(isu_pkg::REG_TH_DE8, isu_pkg::IV_W'(8000));
        write_reg(isu_pkg::REG_INTERVAL, isu_pkg::IV_W'(1));
        write_reg(REG_SPARE, isu_pkg::IV_W'($urandom));
        queue_random(300);
        repeat (20) @(posedge aclk);
        hold_requests++;
        settle();

        // Largest interval: at most one more report follows
        src_idle_pct = 0;
        sink_stall_pct = 0;
        write_reg(isu_pkg::REG_TH_DE4, isu_pkg::IV_W'($urandom_range(0, 65536)));
        write_reg(isu_pkg::REG_TH_DE8, isu_pkg::IV_W'($urandom_range(0, 65536)));
        write_reg(isu_pkg::REG_INTERVAL, {isu_pkg::IV_W{1'b1}});
        queue_random(150);
        settle();

        $display("Run: %0d loads, %0d steps, %0d register writes",
                 load_count, step_count, cfg_writes);
        $display("Uphill moves %0d taken, %0d refused; reports checked %0d, mismatches %0d",
                 uphill_accepts, uphill_rejects, reports_checked, mismatch_count);
        if (mismatch_count == 0 && expected_reports.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

>>> filelist.f
+incdir+hw/rtl
hw/rtl/isu_pkg.sv
hw/rtl/isu_lattice_ram.sv
hw/rtl/isu_seq.sv
hw/rtl/ising_metropolis_spin_update.sv
hw/rtl/isu_checker.sv
tb/tb_ising_metropolis_spin_update.sv
